// File: sv/maf_pkg.sv
// ----------------------------------------------------------------------------
// maf_pkg
// Shared types and constants for the moving average filter.
// ----------------------------------------------------------------------------
package maf_pkg;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned LENGTH_W = 6;

    localparam logic [SAMPLE_W-1:0] INVALID_SAMPLE = 16'hFFFF;
    localparam logic [LENGTH_W-1:0] LENGTH_RESET   = 6'd8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_DIV,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic update;
        logic div_step;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic in_invalid;
        logic div_last;
        logic out_free;
    } t_status;

endpackage

// File: sv/maf_ram.sv
// ----------------------------------------------------------------------------
// maf_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module maf_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 32,
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/maf_ctrl.sv
// ----------------------------------------------------------------------------
// maf_ctrl
// Sequencer for the moving average filter: accept, update, divide, deliver.
// ----------------------------------------------------------------------------
module maf_ctrl
    import maf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_stall
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = i_status.in_invalid ? S_DONE : S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            S_DONE: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// File: sv/maf_dp.sv
// ----------------------------------------------------------------------------
// maf_dp
// Datapath: window ring, running sum, restoring divider and output register.
// ----------------------------------------------------------------------------
module maf_dp
    import maf_pkg::*;
#(
    parameter int unsigned MAX_WINDOW = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_cfg_we,
    input  logic [LENGTH_W-1:0] i_cfg_wdata,
    input  logic                i_stall,
    output logic                o_valid,
    output logic [SAMPLE_W-1:0] o_average
);

    localparam int unsigned POS_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int unsigned CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int unsigned SUM_W  = $clog2(MAX_WINDOW * 65534 + 1);
    localparam int unsigned ITER_W = $clog2(SUM_W + 1);
    localparam int unsigned CMP_W  = (CNT_W > LENGTH_W) ? CNT_W : LENGTH_W;

    logic [LENGTH_W-1:0] r_len;
    logic [POS_W-1:0]    r_wp;
    logic                r_full;
    logic [SUM_W-1:0]    r_sum;
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_bypass;
    logic [SUM_W-1:0]    r_quo;
    logic [CNT_W-1:0]    r_rem;
    logic [CNT_W-1:0]    r_div;
    logic [ITER_W-1:0]   r_iter;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_average;

    logic [CMP_W-1:0]    len_ext;
    logic [CNT_W-1:0]    eff_len;
    logic [CNT_W-1:0]    pos;
    logic [CNT_W-1:0]    pos_inc;
    logic [CNT_W-1:0]    n_pos;
    logic                n_full;
    logic [CNT_W-1:0]    n_count;
    logic [SUM_W-1:0]    n_sum;
    logic [SAMPLE_W-1:0] rd_data;
    logic [CNT_W:0]      shifted;
    logic                ge;
    logic [CNT_W:0]      diff;
    logic                out_take;

    // effective window length: zero acts as one, saturate at the store depth
    always_comb begin
        len_ext = CMP_W'(r_len);
        if (len_ext == '0) begin
            len_ext = CMP_W'(1);
        end else if (len_ext > CMP_W'(MAX_WINDOW)) begin
            len_ext = CMP_W'(MAX_WINDOW);
        end
        eff_len = CNT_W'(len_ext);
    end

    // write slot, next slot and sample count
    always_comb begin
        pos = CNT_W'(r_wp);
        if (pos >= eff_len) begin
            pos = '0;
        end
        pos_inc = pos + CNT_W'(1);
        n_full  = r_full;
        n_pos   = pos_inc;
        if (pos_inc >= eff_len) begin
            n_pos  = '0;
            n_full = 1'b1;
        end
        n_count = n_full ? eff_len : n_pos;
        if (n_count == '0) begin
            n_count = CNT_W'(1);
        end
    end

    // running sum: add the new sample, drop the overwritten one once full
    assign n_sum = r_sum - (r_full ? SUM_W'(rd_data) : '0) + SUM_W'(r_sample);

    // window ring; read address follows the write slot so data is ready at update
    maf_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WINDOW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.update),
        .i_waddr (POS_W'(pos)),
        .i_wdata (r_sample),
        .i_raddr (POS_W'(pos)),
        .o_rdata (rd_data)
    );

    // filter state and window length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= LENGTH_RESET;
            r_wp   <= '0;
            r_full <= 1'b0;
            r_sum  <= '0;
        end else if (i_cfg_we) begin
            r_len  <= i_cfg_wdata;
            r_wp   <= '0;
            r_full <= 1'b0;
            r_sum  <= '0;
        end else if (i_cmd.update) begin
            r_wp   <= POS_W'(n_pos);
            r_full <= n_full;
            r_sum  <= n_sum;
        end
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
            r_bypass <= (i_sample == INVALID_SAMPLE);
        end
    end

    // restoring divider step, one quotient bit per cycle
    always_comb begin
        shifted = {r_rem, r_quo[SUM_W-1]};
        ge      = (shifted >= {1'b0, r_div});
        diff    = shifted - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_quo <= n_sum;
            r_rem <= '0;
            r_div <= n_count;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[SUM_W-2:0], ge};
            r_rem <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter <= '0;
        end else if (i_cmd.update) begin
            r_iter <= ITER_W'(SUM_W);
        end else if (i_cmd.div_step) begin
            r_iter <= r_iter - ITER_W'(1);
        end
    end

    // output register, refilled as soon as the held beat is taken
    assign out_take = r_out_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_average <= r_bypass ? INVALID_SAMPLE : r_quo[SAMPLE_W-1:0];
        end
    end

    assign o_status.in_invalid = (i_sample == INVALID_SAMPLE);
    assign o_status.div_last   = (r_iter == ITER_W'(1));
    assign o_status.out_free   = !r_out_valid || !i_stall;

    assign o_valid   = r_out_valid;
    assign o_average = r_average;

endmodule

// File: sv/moving_average_filter.sv
// ----------------------------------------------------------------------------
// moving_average_filter
// Mean of the most recent distance samples over a programmable window.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+-------------------
//  sample  | in        | i_valid/o_stall  | i_sample[15:0]
//  average | out       | o_valid/i_stall  | o_average[15:0]
//  config  | in        | i_cfg_we         | i_cfg_wdata[5:0]
//
// a valid sample goes from accept through the update and divide states to the
// output register (SUM_W = clog2(MAX_WINDOW*65534+1) quotient bits), one bit per
// cycle from the restoring divider; an invalid marker skips straight to output.
// the sequencer then returns to idle before it takes the next sample.
// one sample at a time; the next is taken while the last beat still waits.
// synchronous active-low reset; no clearing pass, ring entries are read
// only after they are written. a stalled output holds the divider result.
// ----------------------------------------------------------------------------
module moving_average_filter
    import maf_pkg::*;
#(
    parameter int unsigned MAX_WINDOW = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [SAMPLE_W-1:0] i_sample,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [SAMPLE_W-1:0] o_average,
    input  logic                i_cfg_we,
    input  logic [LENGTH_W-1:0] i_cfg_wdata
);

    t_cmd    cmd;
    t_status status;

    // sequencer
    maf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_status (status),
        .o_cmd    (cmd),
        .o_stall  (o_stall)
    );

    // datapath
    maf_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_sample    (i_sample),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_average   (o_average)
    );

    // checks

    // busy in the cycle after every accepted sample
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input accepted while previous sample in flight");

    // a result is only loaded when the output register can take it
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_valid || !i_stall))
        else $error("output beat overwritten before taken");

    // divider and ring update never overlap input capture or output load
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.update, cmd.div_step, cmd.out_load}))
        else $error("overlapping datapath commands");

    // reset leaves the block empty and ready
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("block not idle after reset");

endmodule
